// ===== rtl/spherical_to_cartesian_return_unit_assert.svh =====
// Assertion macros for the spherical-to-Cartesian return unit.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef SPHERICAL_TO_CARTESIAN_RETURN_UNIT_ASSERT_SVH
`define SPHERICAL_TO_CARTESIAN_RETURN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define S2C_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2c: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define S2C_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2c: next-cycle check failed");

`endif

// ===== rtl/s2c_pkg.sv =====
// Shared types, constants and CORDIC helper functions for the
// spherical-to-Cartesian return unit. No dependencies.
`timescale 1ns / 1ps

package s2c_pkg;

    // Fixed port widths.
    localparam int RANGE_W = 24;
    localparam int ANGLE_W = 16;
    localparam int VEL_W   = 24;
    localparam int AMP_W   = 24;
    localparam int ID_W    = 16;
    localparam int POS_W   = 25;

    // Parameter defaults.
    localparam int DEF_RANGE_BITS   = 24;
    localparam int DEF_ANGLE_BITS   = 16;
    localparam int DEF_CORDIC_STEPS = 18;

    // Internal CORDIC widths: x/y in Q30, z in 2^32 units per turn.
    localparam int XY_W   = 33;
    localparam int Z_W    = 34;
    localparam int UNIT_W = 32;
    localparam int MAG_W  = 31;

    localparam logic signed [XY_W-1:0]   CORDIC_K  = 33'sd652032874;
    localparam logic signed [XY_W-1:0]   Q30_P     = 33'sd1073741824;
    localparam logic signed [XY_W-1:0]   Q30_M     = -33'sd1073741824;
    localparam logic signed [UNIT_W-1:0] UNIT_ONE  = 32'sd1073741824;
    localparam logic signed [UNIT_W-1:0] UNIT_MONE = -32'sd1073741824;

    typedef enum logic [1:0] {
        QD_0   = 2'd0,
        QD_90  = 2'd1,
        QD_180 = 2'd2,
        QD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        t_quad                  quad;
    } t_rot;

    typedef struct packed {
        logic signed [UNIT_W-1:0] c;
        logic signed [UNIT_W-1:0] s;
    } t_cs;

    typedef struct packed {
        logic [MAG_W-1:0] mag_c;
        logic [MAG_W-1:0] mag_s;
        logic             neg_c;
        logic             neg_s;
    } t_trig;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic [AMP_W-1:0]        amp;
        logic [ID_W-1:0]         id;
    } t_side;

    // round(atan(2^-k) * 2^31 / pi)
    function automatic logic signed [Z_W-1:0] atan_q32(input logic [4:0] k);
        logic signed [Z_W-1:0] v;
        case (k)
            5'd0:    v = Z_W'(536870912);
            5'd1:    v = Z_W'(316933406);
            5'd2:    v = Z_W'(167458907);
            5'd3:    v = Z_W'(85004756);
            5'd4:    v = Z_W'(42667331);
            5'd5:    v = Z_W'(21354465);
            5'd6:    v = Z_W'(10679838);
            5'd7:    v = Z_W'(5340245);
            5'd8:    v = Z_W'(2670163);
            5'd9:    v = Z_W'(1335087);
            5'd10:   v = Z_W'(667544);
            5'd11:   v = Z_W'(333772);
            5'd12:   v = Z_W'(166886);
            5'd13:   v = Z_W'(83443);
            5'd14:   v = Z_W'(41722);
            5'd15:   v = Z_W'(20861);
            5'd16:   v = Z_W'(10430);
            5'd17:   v = Z_W'(5215);
            5'd18:   v = Z_W'(2608);
            5'd19:   v = Z_W'(1304);
            5'd20:   v = Z_W'(652);
            5'd21:   v = Z_W'(326);
            5'd22:   v = Z_W'(163);
            5'd23:   v = Z_W'(81);
            5'd24:   v = Z_W'(41);
            5'd25:   v = Z_W'(20);
            5'd26:   v = Z_W'(10);
            5'd27:   v = Z_W'(5);
            5'd28:   v = Z_W'(3);
            5'd29:   v = Z_W'(1);
            5'd30:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // One rotation-mode micro-rotation; the quadrant rides along unchanged.
    function automatic t_rot cordic_step(input t_rot c, input logic [4:0] k);
        t_rot                   n;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        n  = c;
        x  = c.x;
        y  = c.y;
        dx = y >>> k;
        dy = x >>> k;
        if (!c.z[Z_W-1]) begin
            n.x = x - dx;
            n.y = y + dy;
            n.z = c.z - atan_q32(k);
        end else begin
            n.x = x + dx;
            n.y = y - dy;
            n.z = c.z + atan_q32(k);
        end
        return n;
    endfunction

    function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = v;
        if (v > Q30_P) begin
            t = Q30_P;
        end else if (v < Q30_M) begin
            t = Q30_M;
        end
        return UNIT_W'(t);
    endfunction

    // Undo the quadrant reduction and clamp both results to the unit range.
    function automatic t_cs unit_map(input t_rot r);
        t_cs                    o;
        logic signed [XY_W-1:0] c;
        logic signed [XY_W-1:0] s;
        case (r.quad)
            QD_0: begin
                c = r.x;
                s = r.y;
            end
            QD_90: begin
                c = -r.y;
                s = r.x;
            end
            QD_180: begin
                c = -r.x;
                s = -r.y;
            end
            default: begin
                c = r.y;
                s = -r.x;
            end
        endcase
        o.c = clamp_unit(c);
        o.s = clamp_unit(s);
        return o;
    endfunction

    function automatic t_trig to_trig(input t_cs v);
        t_trig o;
        o.neg_c = v.c[UNIT_W-1];
        o.neg_s = v.s[UNIT_W-1];
        o.mag_c = o.neg_c ? MAG_W'(-v.c) : MAG_W'(v.c);
        o.mag_s = o.neg_s ? MAG_W'(-v.s) : MAG_W'(v.s);
        return o;
    endfunction

endpackage

// ===== rtl/spherical_to_cartesian_return_unit.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// input    | in        | i_valid / o_stall  | range, elevation, azimuth, doppler, amp, id
// output   | out       | o_valid / i_stall  | pos x/y/z, velocity x/y/z, amplitude, id
//
// Flow: one transfer per clock on each side while no stall holds it; the depth is
// set by the CORDIC pipeline, which spends one register stage per micro-rotation.
// Reset: synchronous, active low; it clears only the per-stage valid bits.
// Stalls: a held output keeps its stage; earlier stages keep moving into empty
// slots, so o_stall rises only when every stage holds an item and i_stall is high.
//
// Spherical-to-Cartesian conversion of radar returns, one module.
// Depends on s2c_pkg and spherical_to_cartesian_return_unit_assert.svh.
`timescale 1ns / 1ps
`include "spherical_to_cartesian_return_unit_assert.svh"

module spherical_to_cartesian_return_unit #(
    parameter int RANGE_BITS   = s2c_pkg::DEF_RANGE_BITS,
    parameter int ANGLE_BITS   = s2c_pkg::DEF_ANGLE_BITS,
    parameter int CORDIC_STEPS = s2c_pkg::DEF_CORDIC_STEPS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [s2c_pkg::RANGE_W-1:0]        i_target_range,
    input  logic signed [s2c_pkg::ANGLE_W-1:0] i_elevation_angle,
    input  logic signed [s2c_pkg::ANGLE_W-1:0] i_azimuth_angle,
    input  logic signed [s2c_pkg::VEL_W-1:0]   i_doppler_x,
    input  logic signed [s2c_pkg::VEL_W-1:0]   i_doppler_y,
    input  logic signed [s2c_pkg::VEL_W-1:0]   i_doppler_z,
    input  logic [s2c_pkg::AMP_W-1:0]          i_amplitude_in,
    input  logic [s2c_pkg::ID_W-1:0]           i_object_id_in,
    // Output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [s2c_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [s2c_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [s2c_pkg::POS_W-1:0]   o_pos_z,
    output logic signed [s2c_pkg::VEL_W-1:0]   o_vel_x,
    output logic signed [s2c_pkg::VEL_W-1:0]   o_vel_y,
    output logic signed [s2c_pkg::VEL_W-1:0]   o_vel_z,
    output logic [s2c_pkg::AMP_W-1:0]          o_amplitude_out,
    output logic [s2c_pkg::ID_W-1:0]           o_object_id_out
);
    import s2c_pkg::*;

    // Stage map: stage 0 reduces both angles to one eighth turn around zero,
    // stages 1..N each run one micro-rotation on both angles side by side,
    // then the quadrant is undone and clamped, the signs are split off, and
    // the two products are formed and rounded in separate stages.
    localparam int N      = CORDIC_STEPS;
    localparam int S_MAP  = N + 1;
    localparam int S_ABS  = N + 2;
    localparam int S_OUT  = N + 6;
    localparam int NS     = N + 7;

    // Product widths and rounding points. The horizontal projection h keeps
    // HFRAC fraction bits so that it always fits 32 bits.
    localparam int HFRAC  = 32 - RANGE_BITS;
    localparam int H_W    = 32;
    localparam int PH_W   = RANGE_BITS + MAG_W;
    localparam int PXY_W  = H_W + MAG_W;
    localparam int SH_H   = RANGE_BITS - 2;
    localparam int SH_Z   = 30;
    localparam int SH_XY  = 30 + HFRAC;

    localparam logic [PH_W-1:0]       HALF_H    = PH_W'(1) << (SH_H - 1);
    localparam logic [PH_W-1:0]       HALF_Z    = PH_W'(1) << (SH_Z - 1);
    localparam logic [PXY_W-1:0]      HALF_XY   = PXY_W'(1) << (SH_XY - 1);
    localparam logic [ANGLE_BITS-1:0] EIGHTH    = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

    // Shift the angle by one eighth turn: the top two bits give the quadrant
    // and the rest, re-centered, becomes the CORDIC start angle in 2^32 units.
    function automatic t_rot angle_start(input logic [ANGLE_BITS-1:0] ang);
        logic [ANGLE_BITS-1:0] a;
        t_rot                  r;
        a      = ang + EIGHTH;
        r.quad = t_quad'(a[ANGLE_BITS-1 -: 2]);
        r.z    = (Z_W'(a[ANGLE_BITS-3:0]) - Z_W'(EIGHTH)) << (32 - ANGLE_BITS);
        r.x    = CORDIC_K;
        r.y    = '0;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Flow control. A stage may load when it is empty or when every
    // stage after it will move; that is the case unless all of them are
    // full and the consumer stalls.
    // ---------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] w_en;

    genvar gs;
    generate
        for (gs = 0; gs < NS; gs++) begin : g_en
            assign w_en[gs] = ~((&r_v[NS-1:gs]) & i_stall);
        end
    endgenerate

    assign n_v = {r_v[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~w_en) | (n_v & w_en);
        end
    end

    assign o_stall = ~w_en[0];
    assign o_valid = r_v[NS-1];

    // ---------------------------------------------------------------
    // Input conditioning: only the low RANGE_BITS and ANGLE_BITS bits
    // take part; missing upper bits read as zero.
    // ---------------------------------------------------------------
    logic [RANGE_BITS-1:0] n_rng_in;
    logic [ANGLE_BITS-1:0] n_ang_el;
    logic [ANGLE_BITS-1:0] n_ang_az;
    t_side                 n_side_in;

    generate
        if (RANGE_BITS > RANGE_W) begin : g_rng_wide
            assign n_rng_in = {{(RANGE_BITS - RANGE_W){1'b0}}, i_target_range};
        end else begin : g_rng_narrow
            assign n_rng_in = i_target_range[RANGE_BITS-1:0];
        end
        if (ANGLE_BITS > ANGLE_W) begin : g_ang_wide
            assign n_ang_el = {{(ANGLE_BITS - ANGLE_W){1'b0}}, i_elevation_angle};
            assign n_ang_az = {{(ANGLE_BITS - ANGLE_W){1'b0}}, i_azimuth_angle};
        end else begin : g_ang_narrow
            assign n_ang_el = i_elevation_angle[ANGLE_BITS-1:0];
            assign n_ang_az = i_azimuth_angle[ANGLE_BITS-1:0];
        end
    endgenerate

    assign n_side_in.vel_x = i_doppler_x;
    assign n_side_in.vel_y = i_doppler_y;
    assign n_side_in.vel_z = i_doppler_z;
    assign n_side_in.amp   = i_amplitude_in;
    assign n_side_in.id    = i_object_id_in;

    // ---------------------------------------------------------------
    // Pass-through fields and range travel alongside the arithmetic.
    // ---------------------------------------------------------------
    t_side                 r_side [0:NS-1];
    logic [RANGE_BITS-1:0] r_rng  [0:S_ABS];

    generate
        for (gs = 0; gs < NS; gs++) begin : g_side
            if (gs == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (w_en[gs]) begin
                        r_side[gs] <= n_side_in;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge i_clk) begin
                    if (w_en[gs]) begin
                        r_side[gs] <= r_side[gs-1];
                    end
                end
            end
        end
        for (gs = 0; gs <= S_ABS; gs++) begin : g_rng
            if (gs == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (w_en[gs]) begin
                        r_rng[gs] <= n_rng_in;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge i_clk) begin
                    if (w_en[gs]) begin
                        r_rng[gs] <= r_rng[gs-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Angle reduction and the CORDIC pipeline, elevation and azimuth
    // in parallel. Stage i holds the vector after i micro-rotations.
    // ---------------------------------------------------------------
    t_rot r_rot_el [0:N];
    t_rot r_rot_az [0:N];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rot_el[0] <= angle_start(n_ang_el);
            r_rot_az[0] <= angle_start(n_ang_az);
        end
    end

    generate
        for (gs = 1; gs <= N; gs++) begin : g_cordic
            always_ff @(posedge i_clk) begin
                if (w_en[gs]) begin
                    r_rot_el[gs] <= cordic_step(r_rot_el[gs-1], 5'(gs - 1));
                    r_rot_az[gs] <= cordic_step(r_rot_az[gs-1], 5'(gs - 1));
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Quadrant restore with clamp, then sign and magnitude split.
    // ---------------------------------------------------------------
    t_cs   r_cs_el;
    t_cs   r_cs_az;
    t_trig r_tr_el;
    t_trig r_tr_az;

    always_ff @(posedge i_clk) begin
        if (w_en[S_MAP]) begin
            r_cs_el <= unit_map(r_rot_el[N]);
            r_cs_az <= unit_map(r_rot_az[N]);
        end
        if (w_en[S_ABS]) begin
            r_tr_el <= to_trig(r_cs_el);
            r_tr_az <= to_trig(r_cs_az);
        end
    end

    // ---------------------------------------------------------------
    // First products: h = range * |cos(el)| and z = range * |sin(el)|.
    // The next stage rounds both to nearest, halves up.
    // ---------------------------------------------------------------
    logic [PH_W-1:0]  r_hprod;
    logic [PH_W-1:0]  r_zprod;
    logic             r_hneg1;
    logic             r_zneg1;
    t_trig            r_tr_az1;
    logic [PH_W-1:0]  n_hsum;
    logic [PH_W-1:0]  n_hshift;
    logic [PH_W-1:0]  n_zsum;
    logic [PH_W-1:0]  n_zshift;
    logic [H_W-1:0]   r_h;
    logic [POS_W-1:0] r_pz2;
    logic             r_hneg2;
    logic             r_zneg2;
    t_trig            r_tr_az2;

    always_ff @(posedge i_clk) begin
        if (w_en[S_ABS+1]) begin
            r_hprod  <= PH_W'(r_rng[S_ABS]) * PH_W'(r_tr_el.mag_c);
            r_zprod  <= PH_W'(r_rng[S_ABS]) * PH_W'(r_tr_el.mag_s);
            r_hneg1  <= r_tr_el.neg_c;
            r_zneg1  <= r_tr_el.neg_s;
            r_tr_az1 <= r_tr_az;
        end
    end

    always_comb begin
        n_hsum   = r_hprod + HALF_H;
        n_hshift = n_hsum >> SH_H;
        n_zsum   = r_zprod + HALF_Z;
        n_zshift = n_zsum >> SH_Z;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_ABS+2]) begin
            r_h      <= n_hshift[H_W-1:0];
            r_pz2    <= n_zshift[POS_W-1:0];
            r_hneg2  <= r_hneg1;
            r_zneg2  <= r_zneg1;
            r_tr_az2 <= r_tr_az1;
        end
    end

    // ---------------------------------------------------------------
    // Second products: x and y from h and the azimuth terms. The sign of
    // each position is the product of the signs of its factors.
    // ---------------------------------------------------------------
    logic [PXY_W-1:0] r_xprod;
    logic [PXY_W-1:0] r_yprod;
    logic             r_xneg3;
    logic             r_yneg3;
    logic             r_zneg3;
    logic [POS_W-1:0] r_pz3;

    always_ff @(posedge i_clk) begin
        if (w_en[S_ABS+3]) begin
            r_xprod <= PXY_W'(r_h) * PXY_W'(r_tr_az2.mag_c);
            r_yprod <= PXY_W'(r_h) * PXY_W'(r_tr_az2.mag_s);
            r_xneg3 <= r_hneg2 ^ r_tr_az2.neg_c;
            r_yneg3 <= r_hneg2 ^ r_tr_az2.neg_s;
            r_zneg3 <= r_zneg2;
            r_pz3   <= r_pz2;
        end
    end

    // ---------------------------------------------------------------
    // Output register: round x and y, apply signs and keep the low 25
    // bits. A magnitude that rounds to zero stays zero when negated.
    // ---------------------------------------------------------------
    logic [PXY_W-1:0] n_xsum;
    logic [PXY_W-1:0] n_xshift;
    logic [PXY_W-1:0] n_ysum;
    logic [PXY_W-1:0] n_yshift;
    logic [POS_W-1:0] n_xm;
    logic [POS_W-1:0] n_ym;
    logic [POS_W-1:0] r_px;
    logic [POS_W-1:0] r_py;
    logic [POS_W-1:0] r_pzo;

    always_comb begin
        n_xsum   = r_xprod + HALF_XY;
        n_xshift = n_xsum >> SH_XY;
        n_ysum   = r_yprod + HALF_XY;
        n_yshift = n_ysum >> SH_XY;
        n_xm     = n_xshift[POS_W-1:0];
        n_ym     = n_yshift[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_px  <= r_xneg3 ? (POS_W'(0) - n_xm) : n_xm;
            r_py  <= r_yneg3 ? (POS_W'(0) - n_ym) : n_ym;
            r_pzo <= r_zneg3 ? (POS_W'(0) - r_pz3) : r_pz3;
        end
    end

    assign o_pos_x         = r_px;
    assign o_pos_y         = r_py;
    assign o_pos_z         = r_pzo;
    assign o_vel_x         = r_side[NS-1].vel_x;
    assign o_vel_y         = r_side[NS-1].vel_y;
    assign o_vel_z         = r_side[NS-1].vel_z;
    assign o_amplitude_out = r_side[NS-1].amp;
    assign o_object_id_out = r_side[NS-1].id;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // The input side only stalls once every stage is occupied.
    `S2C_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, o_stall, (&r_v))
    // A stage that cannot move keeps its item.
    `S2C_ASSERT_NEXT(a_mid_stage_holds, i_clk, i_rst_n, (r_v[S_ABS] && !w_en[S_ABS]), r_v[S_ABS])
    // A taken result with nothing behind it leaves the output empty.
    `S2C_ASSERT_NEXT(a_no_repeat, i_clk, i_rst_n, (r_v[S_OUT] && !i_stall && !r_v[S_OUT-1]), !r_v[S_OUT])
    // The clamp keeps every sine and cosine inside the unit range.
    `S2C_ASSERT_IMPL(a_unit_range, i_clk, i_rst_n, r_v[S_MAP], (r_cs_el.c <= UNIT_ONE && r_cs_el.c >= UNIT_MONE && r_cs_el.s <= UNIT_ONE && r_cs_el.s >= UNIT_MONE && r_cs_az.c <= UNIT_ONE && r_cs_az.c >= UNIT_MONE && r_cs_az.s <= UNIT_ONE && r_cs_az.s >= UNIT_MONE))

endmodule
